@@ hdl/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle rule");

// next-cycle implication, checked on every rising edge outside reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle rule");

`endif

@@ hdl/tsli_pkg.sv @@
package tsli_pkg;

    // field widths
    localparam int TIME_W      = 32;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 32;
    localparam int DIV_STEPS   = 32;
    localparam int STEP_W      = 5;

    // operation codes carried on s_tuser
    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // status codes carried on m_tuser
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_DATA = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd2;

    // request to the shared multiply/divide unit
    typedef struct packed {
        logic              start;
        logic [VALUE_W-1:0] mag;
        logic [TIME_W-1:0]  num;
        logic [TIME_W-1:0]  span;
    } md_req_t;

    // response from the shared multiply/divide unit
    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quo;
    } md_rsp_t;

endpackage

@@ hdl/timed_sample_linear_interpolator.sv @@
// Timed-sample linear interpolator. A push transaction (s_tuser = 0) stores a
// (time, value) sample in a FIFO of FIFO_DEPTH entries and gives no result,
// unless the FIFO is full, in which case the sample is dropped and a result
// with status 2 comes back. A query (s_tuser = 1) first retires every head
// sample older than the query time, each one becoming the anchor, then
// returns the linear interpolation between anchor and head in signed Q16.16
// (status 0; the anchor value when the query is before the anchor, the head
// value when the head is not after the anchor), or zero with status 1 when
// no sample is left. The block takes one transaction at a time: a query does
// one sample memory read per retired sample and, when a real interpolation is
// needed, one product, 32 quotient steps and a hand-back of the quotient in
// the shared multiply/divide unit. A finished result sits in an output
// register, so the next transaction can be taken while it waits for m_tready.
module timed_sample_linear_interpolator #(
    parameter int FIFO_DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] sample_time, [63:32] sample_value
    input  logic [tsli_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] func
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] result_value
    output logic [tsli_pkg::M_TDATA_W-1:0]    m_tdata,
    // [1:0] status
    output logic [tsli_pkg::STATUS_W-1:0]     m_tuser
);

    import tsli_pkg::*;

    localparam int ADDR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_CHECK = 5'b00100,
        S_CALC  = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   head_reg, head_next;
    logic [ADDR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TIME_W-1:0]   anchor_time_reg, anchor_time_next;
    logic [VALUE_W-1:0]  anchor_value_reg, anchor_value_next;
    logic                first_reg, first_next;
    logic [TIME_W-1:0]   qtime_reg, qtime_next;
    logic                neg_reg, neg_next;
    logic [VALUE_W-1:0]  res_value_reg, res_value_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]  out_value_reg, out_value_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic                in_fire;
    logic                full;
    logic                ram_we;
    logic [S_TDATA_W-1:0] ram_rdata;
    logic [TIME_W-1:0]   in_time;
    logic [VALUE_W-1:0]  in_value;
    logic [TIME_W-1:0]   head_time;
    logic [VALUE_W-1:0]  head_value;
    logic [VALUE_W:0]    diff;
    logic [VALUE_W:0]    diff_abs;
    logic                out_free;
    md_req_t             md_req;
    md_rsp_t             md_rsp;

    assign in_time    = s_tdata[TIME_W-1:0];
    assign in_value   = s_tdata[S_TDATA_W-1:TIME_W];
    assign head_time  = ram_rdata[TIME_W-1:0];
    assign head_value = ram_rdata[S_TDATA_W-1:TIME_W];
    assign s_tready   = (state_reg == S_IDLE);
    assign in_fire    = s_tvalid && s_tready;
    assign full       = (count_reg == CNT_W'(FIFO_DEPTH));
    assign ram_we     = in_fire && (s_tuser == FUNC_PUSH) && !full;
    assign out_free   = !out_valid_reg || m_tready;

    // signed distance between head value and anchor value
    assign diff     = {head_value[VALUE_W-1], head_value}
                    - {anchor_value_reg[VALUE_W-1], anchor_value_reg};
    assign diff_abs = diff[VALUE_W] ? (~diff + 1'b1) : diff;

    // sample store, value in the upper half
    tsli_ram #(
        .WIDTH (S_TDATA_W),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata ({in_value, in_time}),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // shared multiply and iterative divide
    tsli_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    always_comb
    begin
        md_req.start = 1'b0;
        md_req.mag   = diff_abs[VALUE_W-1:0];
        md_req.num   = qtime_reg - anchor_time_reg;
        md_req.span  = head_time - anchor_time_reg;

        state_next        = state_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        anchor_time_next  = anchor_time_reg;
        anchor_value_next = anchor_value_reg;
        first_next        = first_reg;
        qtime_next        = qtime_reg;
        neg_next          = neg_reg;
        res_value_next    = res_value_reg;
        res_status_next   = res_status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_tuser == FUNC_QUERY)
                    begin
                        qtime_next = in_time;
                        state_next = S_READ;
                    end
                    else if (full)
                    begin
                        res_value_next  = '0;
                        res_status_next = ST_DROPPED;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        if (first_reg)
                        begin
                            anchor_time_next  = '0;
                            anchor_value_next = in_value;
                            first_next        = 1'b0;
                        end
                        tail_next  = (tail_reg == ADDR_W'(FIFO_DEPTH - 1)) ? '0
                                   : tail_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                priority if (count_reg == '0)
                begin
                    res_value_next  = '0;
                    res_status_next = ST_NO_DATA;
                    state_next      = S_OUT;
                end
                else if (qtime_reg > head_time)
                begin
                    // retire the head, it becomes the anchor
                    anchor_time_next  = head_time;
                    anchor_value_next = head_value;
                    head_next  = (head_reg == ADDR_W'(FIFO_DEPTH - 1)) ? '0
                               : head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                    state_next = S_READ;
                end
                else if (qtime_reg < anchor_time_reg)
                begin
                    res_value_next  = anchor_value_reg;
                    res_status_next = ST_OK;
                    state_next      = S_OUT;
                end
                else if (head_time <= anchor_time_reg)
                begin
                    res_value_next  = head_value;
                    res_status_next = ST_OK;
                    state_next      = S_OUT;
                end
                else
                begin
                    md_req.start = 1'b1;
                    neg_next     = diff[VALUE_W];
                    state_next   = S_CALC;
                end
            end
            S_CALC:
            begin
                if (md_rsp.done)
                begin
                    res_value_next  = neg_reg ? (anchor_value_reg - md_rsp.quo)
                                    : (anchor_value_reg + md_rsp.quo);
                    res_status_next = ST_OK;
                    state_next      = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        if ((state_reg == S_OUT) && out_free)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = res_value_reg;
            out_status_next = res_status_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            anchor_time_reg  <= '0;
            anchor_value_reg <= '0;
            first_reg        <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            count_reg        <= count_next;
            anchor_time_reg  <= anchor_time_next;
            anchor_value_reg <= anchor_value_next;
            first_reg        <= first_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        qtime_reg      <= qtime_next;
        neg_reg        <= neg_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;

endmodule

@@ hdl/tsli_ram.sv @@
module tsli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/tsli_muldiv.sv @@
module tsli_muldiv (
    input  logic              clk,
    input  logic              rst_n,
    input  tsli_pkg::md_req_t req,
    output tsli_pkg::md_rsp_t rsp
);

    import tsli_pkg::*;

    typedef enum logic [2:0] {
        MD_IDLE = 3'b001,
        MD_MUL  = 3'b010,
        MD_DIV  = 3'b100
    } md_state_t;

    md_state_t                state_reg, state_next;
    logic [VALUE_W-1:0]       mag_reg, mag_next;
    logic [TIME_W-1:0]        num_reg, num_next;
    logic [TIME_W-1:0]        span_reg, span_next;
    logic [TIME_W:0]          rem_reg, rem_next;
    logic [VALUE_W-1:0]       quo_reg, quo_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     done_reg, done_next;
    logic [VALUE_W+TIME_W-1:0] prod;
    logic [TIME_W:0]          shifted;
    logic                     fits;

    // one 32x32 product, then one restoring quotient bit per cycle
    assign prod    = mag_reg * num_reg;
    assign shifted = {rem_reg[TIME_W-1:0], quo_reg[VALUE_W-1]};
    assign fits    = shifted >= {1'b0, span_reg};

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        num_next   = num_reg;
        span_next  = span_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    mag_next   = req.mag;
                    num_next   = req.num;
                    span_next  = req.span;
                    state_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                // high half is below the span since num never exceeds it
                rem_next   = {1'b0, prod[VALUE_W+TIME_W-1:VALUE_W]};
                quo_next   = prod[VALUE_W-1:0];
                step_next  = '0;
                state_next = MD_DIV;
            end
            MD_DIV:
            begin
                rem_next  = fits ? (shifted - {1'b0, span_reg}) : shifted;
                quo_next  = {quo_reg[VALUE_W-2:0], fits};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = MD_IDLE;
                end
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
        end
    end

    // operands and partial results
    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        num_reg  <= num_next;
        span_reg <= span_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

@@ hdl/tsli_checker.sv @@
`include "assert_macros.svh"

module tsli_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tsli_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [tsli_pkg::STATUS_W-1:0]   m_tuser
);

    import tsli_pkg::*;

    // a stalled result transaction holds its payload
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // no-data and dropped results carry a zero value
    `ASSERT_SAME(a_zero_value, m_tvalid && (m_tuser == ST_NO_DATA || m_tuser == ST_DROPPED), m_tdata == '0)

    // a query keeps the input side closed while it is worked on
    `ASSERT_NEXT(a_query_busy, s_tvalid && s_tready && (s_tuser == FUNC_QUERY), !s_tready)

    // only the defined status codes appear on a result
    `ASSERT_SAME(a_status_known, m_tvalid, m_tuser <= ST_DROPPED)

endmodule

bind timed_sample_linear_interpolator tsli_checker u_tsli_checker (.*);

@@ bench/tb_timed_sample_linear_interpolator.sv @@
`timescale 1ns / 1ps

module tb_timed_sample_linear_interpolator;

    import tsli_pkg::*;

    localparam int DEPTH = 64;

    // idling per phase, in percent of cycles
    localparam int TX_IDLE[4] = '{0, 53, 0, 22};
    localparam int RX_STALL[4] = '{0, 0, 53, 22};

    localparam logic signed [VALUE_W-1:0] LEVEL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] LEVEL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [VALUE_W-1:0] level;
        logic [STATUS_W-1:0]       code;
    } outcome_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = FUNC_PUSH;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    // sample store mirror
    logic [TIME_W-1:0]         stamp_mem[DEPTH];
    logic signed [VALUE_W-1:0] level_mem[DEPTH];
    int                        rd_ptr = 0;
    int                        wr_ptr = 0;
    int                        store_fill = 0;
    logic [TIME_W-1:0]         anchor_stamp = '0;
    logic signed [VALUE_W-1:0] anchor_level = '0;
    logic                      first_pending = 1'b1;

    outcome_t          pending_results[$];
    int                mismatch_count = 0;
    int                tx_idle_pct = 0;
    int                rx_stall_pct = 0;
    logic [TIME_W-1:0] stamp_cursor = 32'd100;

    timed_sample_linear_interpolator #(
        .FIFO_DEPTH(DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // watchdog
    initial
    begin
        #15_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int next_slot(input int idx);
        return (idx == DEPTH - 1) ? 0 : idx + 1;
    endfunction

    // value on the line from anchor to head at the given time
    function automatic logic signed [VALUE_W-1:0] blend(input logic [TIME_W-1:0] at);
        logic [TIME_W-1:0]         h_stamp;
        logic signed [VALUE_W-1:0] h_level;
        logic [TIME_W-1:0]         num;
        logic [TIME_W-1:0]         span;
        longint                    base;
        longint                    delta;
        logic [63:0]               mag;
        logic [63:0]               quo;
        logic [63:0]               total;
        h_stamp = stamp_mem[rd_ptr];
        h_level = level_mem[rd_ptr];
        if (at < anchor_stamp)
            return anchor_level;
        if (h_stamp <= anchor_stamp)
            return h_level;
        num   = at - anchor_stamp;
        span  = h_stamp - anchor_stamp;
        base  = longint'(anchor_level);
        delta = longint'(h_level) - base;
        mag   = (delta < 0) ? -delta : delta;
        quo   = (mag * {32'd0, num}) / {32'd0, span};
        if (quo > mag)
            quo = mag;
        total = (delta < 0) ? base - longint'(quo) : base + longint'(quo);
        return total[VALUE_W-1:0];
    endfunction

    // mirror of one accepted transaction, queues the result it causes
    function automatic void predict_step(input logic func, input logic [TIME_W-1:0] stamp,
                                         input logic signed [VALUE_W-1:0] level);
        if (func == FUNC_PUSH)
        begin
            if (store_fill >= DEPTH)
            begin
                pending_results.push_back('{level: '0, code: ST_DROPPED});
                return;
            end
            if (first_pending)
            begin
                anchor_stamp  = '0;
                anchor_level  = level;
                first_pending = 1'b0;
            end
            stamp_mem[wr_ptr] = stamp;
            level_mem[wr_ptr] = level;
            wr_ptr = next_slot(wr_ptr);
            store_fill++;
            return;
        end
        // retire every sample older than the query
        while (store_fill > 0 && stamp > stamp_mem[rd_ptr])
        begin
            anchor_stamp = stamp_mem[rd_ptr];
            anchor_level = level_mem[rd_ptr];
            rd_ptr = next_slot(rd_ptr);
            store_fill--;
        end
        if (store_fill == 0)
            pending_results.push_back('{level: '0, code: ST_NO_DATA});
        else
            pending_results.push_back('{level: blend(stamp), code: ST_OK});
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_level();
        case ($urandom_range(9))
            0: return LEVEL_MIN;
            1: return LEVEL_MAX;
            2: return '0;
            3: return -1;
            4, 5: return $urandom_range(32'h000A_0000) - 32'h0005_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] next_gap();
        return ($urandom_range(3) == 0) ? $urandom_range(200000) : $urandom_range(16, 1);
    endfunction

    // one input transaction, with random idle cycles ahead of it
    task automatic send_item(input logic func, input logic [TIME_W-1:0] stamp,
                             input logic signed [VALUE_W-1:0] level);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {level, stamp};
        do
            @(posedge clk);
        while (!s_tready);
        predict_step(func, stamp, level);
    endtask

    // output side: random stalls, compare against oldest expectation
    always @(posedge clk)
    begin
        outcome_t want;
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, got level %h status %0d",
                         $time, m_tdata[VALUE_W-1:0], m_tuser);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[VALUE_W-1:0] !== want.level || m_tuser !== want.code)
                begin
                    mismatch_count++;
                    $display("%0t: expected level %h status %0d, got level %h status %0d",
                             $time, want.level, want.code, m_tdata[VALUE_W-1:0], m_tuser);
                end
            end
        end
    end

    // query on an empty store
    task automatic test_empty_query();
        send_item(FUNC_QUERY, 32'd5, $urandom());
    endtask

    // first push sets the anchor at time zero, head at time zero too
    task automatic test_zero_span();
        send_item(FUNC_PUSH, 32'd0, 32'sh0002_8000);
        send_item(FUNC_PUSH, 32'd1000, -32'sh0001_0000);
        send_item(FUNC_QUERY, 32'd0, $urandom());
    endtask

    // falling and rising slopes, exact head, clamp before anchor, draining
    task automatic test_interpolation();
        send_item(FUNC_QUERY, 32'd250, $urandom());
        send_item(FUNC_QUERY, 32'd1000, $urandom());
        send_item(FUNC_PUSH, 32'd2000, LEVEL_MAX);
        send_item(FUNC_PUSH, 32'd3000, LEVEL_MIN);
        send_item(FUNC_QUERY, 32'd1500, $urandom());
        send_item(FUNC_QUERY, 32'd999, $urandom());
        send_item(FUNC_QUERY, 32'd2500, $urandom());
        send_item(FUNC_QUERY, 32'd3000, $urandom());
        send_item(FUNC_QUERY, 32'd3001, $urandom());
        send_item(FUNC_QUERY, 32'hFFFF_FFFF, $urandom());
    endtask

    // samples pushed out of time order
    task automatic test_out_of_order();
        send_item(FUNC_PUSH, 32'd5000, 32'sh0001_0000);
        send_item(FUNC_PUSH, 32'd4000, 32'sh0002_0000);
        send_item(FUNC_PUSH, 32'd6000, 32'sh0003_0000);
        send_item(FUNC_QUERY, 32'd5001, $urandom());
        send_item(FUNC_QUERY, 32'd4500, $urandom());
        send_item(FUNC_QUERY, 32'd6001, $urandom());
    endtask

    // times at the top of the range
    task automatic test_top_of_time();
        send_item(FUNC_PUSH, 32'hFFFF_FFFD, LEVEL_MIN);
        send_item(FUNC_PUSH, 32'hFFFF_FFFE, LEVEL_MAX);
        send_item(FUNC_QUERY, 32'hFFFF_FFFE, $urandom());
        send_item(FUNC_QUERY, 32'hFFFF_FFFF, $urandom());
    endtask

    // fill the store, push into it while full, then drain
    task automatic test_full_store();
        while (store_fill < DEPTH)
        begin
            send_item(FUNC_PUSH, stamp_cursor, pick_level());
            stamp_cursor += next_gap();
        end
        repeat (3)
            send_item(FUNC_PUSH, stamp_cursor, pick_level());
        send_item(FUNC_QUERY, stamp_cursor + 1, $urandom());
    endtask

    // mostly rising sample streams with queries around the stored times, plus noise
    task automatic test_mixed_traffic(input int count);
        int                pick;
        logic [TIME_W-1:0] at;
        logic [TIME_W-1:0] head_at;
        for (int n = 0; n < count; n++)
        begin
            pick    = $urandom_range(99);
            head_at = (store_fill > 0) ? stamp_mem[rd_ptr] : stamp_cursor;
            if (stamp_cursor > 32'hF000_0000)
            begin
                // time wraps: drain and restart low
                send_item(FUNC_QUERY, 32'hFFFF_FFFE, $urandom());
                stamp_cursor = $urandom_range(1000);
            end
            else if (pick < 42)
            begin
                send_item(FUNC_PUSH, stamp_cursor, pick_level());
                stamp_cursor += next_gap();
            end
            else if (pick < 85)
            begin
                case ($urandom_range(5))
                    0: at = head_at;
                    1: at = head_at + 1;
                    2: at = (head_at > anchor_stamp) ?
                            anchor_stamp + $urandom_range(head_at - anchor_stamp) : head_at;
                    3: at = (anchor_stamp > 0) ? anchor_stamp - 1 : anchor_stamp;
                    4: at = stamp_cursor + $urandom_range(3);
                    default: at = head_at + $urandom_range(100000);
                endcase
                send_item(FUNC_QUERY, at, $urandom());
            end
            else if (pick < 92)
                send_item(FUNC_PUSH, stamp_cursor - $urandom_range(5000), pick_level());
            else if (pick < 95)
                send_item(FUNC_PUSH, $urandom(), $urandom());
            else
                send_item(FUNC_QUERY, $urandom(), $urandom());
        end
    endtask

    // reset, directed checks, then loaded phases
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_query();
        test_zero_span();
        test_interpolation();
        test_out_of_order();
        test_top_of_time();

        stamp_cursor = $urandom_range(1000);
        for (int ph = 0; ph < 4; ph++)
        begin
            tx_idle_pct  = TX_IDLE[ph];
            rx_stall_pct = RX_STALL[ph];
            test_full_store();
            test_mixed_traffic(370);
        end
        s_tvalid <= 1'b0;

        // let outstanding results drain
        rx_stall_pct = 0;
        for (int n = 0; n < 20000 && pending_results.size() != 0; n++)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            mismatch_count++;
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
        end

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
